// ===== sv/pfpm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfpm_pkg
// Shared constants, types and helpers of the per-channel frame peak meter.
// ----------------------------------------------------------------------------
package pfpm_pkg;

    localparam int MAX_CHANNELS = 16;
    localparam int CH_W         = $clog2(MAX_CHANNELS);
    localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);

    localparam int SAMPLE_W     = 32;
    localparam int CHIDX_W      = 8;
    localparam int PEAK_CH_W    = 4;
    localparam int LEVEL_W      = 18;
    localparam int FMT_W        = 2;
    localparam int SRC_W        = 8;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

    localparam logic [FMT_W-1:0] FMT_F32   = 2'd0;
    localparam logic [FMT_W-1:0] FMT_S16   = 2'd1;
    localparam logic [FMT_W-1:0] FMT_S32   = 2'd2;
    localparam logic [FMT_W-1:0] FMT_UNSUP = 2'd3;

    localparam logic [FMT_W-1:0] FMT_RESET   = FMT_S16;
    localparam logic [SRC_W-1:0] CHANS_RESET = 8'd2;

    localparam logic REG_FORMAT   = 1'b0;
    localparam logic REG_CHANNELS = 1'b1;

    typedef struct packed {
        logic [FMT_W-1:0] fmt;
        logic [SRC_W-1:0] chans;
    } t_cfg;

    typedef struct packed {
        logic            upd;
        logic            load;
        logic            last;
        logic            clr;
        logic [CH_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

    function automatic logic [CNT_W-1:0] tracked_count(input logic [SRC_W-1:0] chans);
        if (chans > SRC_W'(MAX_CHANNELS)) begin
            return CNT_W'(MAX_CHANNELS);
        end
        return CNT_W'(chans);
    endfunction

endpackage

// ===== sv/pfpm_sample_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfpm_sample_if
// Sample channel: valid/ready handshake with a tagged audio sample.
// ----------------------------------------------------------------------------
interface pfpm_sample_if import pfpm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_bits;
    logic [CHIDX_W-1:0]  channel_index;
    logic                frame_end;

    modport source (
        output valid, sample_bits, channel_index, frame_end,
        input  ready
    );
    modport sink (
        input  valid, sample_bits, channel_index, frame_end,
        output ready
    );
endinterface

// ===== sv/pfpm_peak_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfpm_peak_if
// Peak report channel: valid/ready handshake with one channel report.
// ----------------------------------------------------------------------------
interface pfpm_peak_if import pfpm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [PEAK_CH_W-1:0] peak_channel;
    logic [LEVEL_W-1:0]   peak_level;
    logic                 last_peak;

    modport source (
        output valid, peak_channel, peak_level, last_peak,
        input  ready
    );
    modport sink (
        input  valid, peak_channel, peak_level, last_peak,
        output ready
    );
endinterface

// ===== sv/per_channel_frame_peak_meter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_channel_frame_peak_meter
// Tracks the absolute peak of each of the first min(source_channels, 16)
// channels and reports the normalized peaks, in Q2.16, at each frame end.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while no flush is running; each sample
// updates its channel's peak in the cycle it transfers. A sample marked as
// frame end that produces reports holds off input until every tracked
// channel has been reported, longer while the report output is stalled,
// because the flush walks the peak registers through their single read
// port, one report per cycle into the output register while it is free.
// The first report is loaded from the flush state. Peaks clear at reset and
// at the end of every frame. Configure only while no reports are pending.
module per_channel_frame_peak_meter import pfpm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pfpm_sample_if.sink           i_sample,
    pfpm_peak_if.source           o_peak,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    pfpm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pfpm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (i_sample.valid),
        .i_frame_end (i_sample.frame_end),
        .i_sts       (sts),
        .o_ready     (i_sample.ready),
        .o_cmd       (cmd)
    );

    pfpm_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_cmd           (cmd),
        .i_sample_bits   (i_sample.sample_bits),
        .i_channel_index (i_sample.channel_index),
        .o_sts           (sts),
        .o_peak          (o_peak)
    );

endmodule

// ===== sv/pfpm_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfpm_regs
// APB configuration registers: sample format and source channel count.
// ----------------------------------------------------------------------------
module pfpm_regs import pfpm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [FMT_W-1:0] r_fmt;
    logic [SRC_W-1:0] r_chans;
    logic             wr_en;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt   <= FMT_RESET;
            r_chans <= CHANS_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_FORMAT:   r_fmt   <= pwdata[FMT_W-1:0];
                REG_CHANNELS: r_chans <= pwdata[SRC_W-1:0];
                default:      r_fmt   <= r_fmt;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_FORMAT:   prdata = APB_DATA_W'(r_fmt);
            REG_CHANNELS: prdata = APB_DATA_W'(r_chans);
            default:      prdata = '0;
        endcase
    end

    assign o_cfg.fmt   = r_fmt;
    assign o_cfg.chans = r_chans;

endmodule

// ===== sv/pfpm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfpm_ctrl
// Controller: accepts samples while idle and sequences the frame-end flush.
// ----------------------------------------------------------------------------
module pfpm_ctrl import pfpm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_valid,
    input  logic i_frame_end,
    input  t_sts i_sts,
    output logic o_ready,
    output t_cmd o_cmd
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_FLUSH = 1'b1;

    logic            r_state;
    logic            n_state;
    logic [CH_W-1:0] r_cnt;
    logic [CH_W-1:0] n_cnt;
    logic [CNT_W-1:0] trk;
    logic            accept;
    logic            flush_ok;
    logic            load;
    logic            last_idx;

    assign trk      = tracked_count(i_cfg.chans);
    assign flush_ok = (i_cfg.fmt != FMT_UNSUP) && (trk != '0);
    assign o_ready  = (r_state == ST_IDLE);
    assign accept   = i_valid && o_ready;
    assign load     = (r_state == ST_FLUSH) && i_sts.out_free;
    assign last_idx = ((CNT_W'(r_cnt) + CNT_W'(1)) == trk);

    assign o_cmd.upd  = accept;
    assign o_cmd.load = load;
    assign o_cmd.last = last_idx;
    assign o_cmd.idx  = r_cnt;
    assign o_cmd.clr  = (accept && i_frame_end && !flush_ok) || (load && last_idx);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_frame_end && flush_ok) begin
                    n_state = ST_FLUSH;
                    n_cnt   = '0;
                end
            end
            ST_FLUSH: begin
                if (load) begin
                    if (last_idx) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_cnt = r_cnt + CH_W'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== sv/pfpm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfpm_datapath
// Datapath: magnitude extraction, running peak registers, level
// normalization and the report output register.
// ----------------------------------------------------------------------------
module pfpm_datapath import pfpm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  t_cmd                i_cmd,
    input  logic [SAMPLE_W-1:0] i_sample_bits,
    input  logic [CHIDX_W-1:0]  i_channel_index,
    output t_sts                o_sts,
    pfpm_peak_if.source         o_peak
);

    localparam int LVL_W = 36;
    localparam int PROD_W = 50;
    localparam logic [PROD_W-1:0] S32_BIAS = PROD_W'(64'd2147483647);
    localparam logic [32:0] S32_DIV2 = 33'h0FFFFFFFE;

    logic [SAMPLE_W-1:0] r_peak [MAX_CHANNELS];
    logic [CH_W-1:0]     rd_addr;
    logic [SAMPLE_W-1:0] rd_data;
    logic [CNT_W-1:0]    trk;
    logic                ch_hit;
    logic [15:0]         v16;
    logic [15:0]         v16_abs;
    logic [SAMPLE_W-1:0] v32_abs;
    logic [SAMPLE_W-1:0] mag;
    logic                mag_ok;
    logic                upd_en;

    logic [PROD_W-1:0]   s32_n;
    logic [17:0]         s32_q0;
    logic [32:0]         s32_rem;
    logic [7:0]          f_exp;
    logic [7:0]          f_sh;
    logic [40:0]         f_sum;
    logic [LVL_W-1:0]    lvl;
    logic [LEVEL_W-1:0]  level;

    logic                 r_out_valid;
    logic [PEAK_CH_W-1:0] r_peak_channel;
    logic [LEVEL_W-1:0]   r_peak_level;
    logic                 r_last_peak;

    assign trk     = tracked_count(i_cfg.chans);
    assign ch_hit  = (i_channel_index < CHIDX_W'(trk));
    assign rd_addr = i_cmd.upd ? i_channel_index[CH_W-1:0] : i_cmd.idx;
    assign rd_data = r_peak[rd_addr];

    assign v16     = i_sample_bits[15:0];
    assign v16_abs = v16[15] ? (16'd0 - v16) : v16;
    assign v32_abs = i_sample_bits[31] ? (32'd0 - i_sample_bits) : i_sample_bits;

    always_comb begin
        mag    = '0;
        mag_ok = 1'b0;
        unique case (i_cfg.fmt)
            FMT_F32: begin
                mag    = {1'b0, i_sample_bits[30:0]};
                mag_ok = (i_sample_bits[30:0] <= 31'h7F800000);
            end
            FMT_S16: begin
                mag    = SAMPLE_W'(v16_abs);
                mag_ok = (v16 != 16'h8000);
            end
            FMT_S32: begin
                mag    = v32_abs;
                mag_ok = (i_sample_bits != 32'h80000000);
            end
            default: begin
                mag    = '0;
                mag_ok = 1'b0;
            end
        endcase
    end

    assign upd_en = i_cmd.upd && ch_hit && mag_ok && (mag > rd_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_peak[i] <= '0;
            end
        end else if (upd_en) begin
            r_peak[rd_addr] <= mag;
        end
    end

    // int32: divide by 2*(2^31-1) with a shift and one correction step
    assign s32_n   = {1'b0, rd_data, 17'd0} + S32_BIAS;
    assign s32_q0  = s32_n[49:32];
    assign s32_rem = {1'b0, s32_n[31:0]} + {14'd0, s32_q0, 1'b0};

    assign f_exp = rd_data[30:23];
    assign f_sh  = 8'd134 - f_exp;
    assign f_sum = 41'({1'b1, rd_data[22:0]}) + (41'd1 << (f_sh - 8'd1));

    always_comb begin
        lvl = '0;
        unique case (i_cfg.fmt)
            FMT_S16: lvl = LVL_W'({rd_data, 1'b0});
            FMT_S32: lvl = LVL_W'(s32_q0) + LVL_W'(s32_rem >= S32_DIV2);
            FMT_F32: begin
                priority if (f_exp == 8'd0) begin
                    lvl = '0;
                end else if (f_exp >= 8'd129) begin
                    lvl = LVL_W'(LEVEL_MAX);
                end else if (f_sh > 8'd40) begin
                    lvl = '0;
                end else begin
                    lvl = LVL_W'(f_sum >> f_sh);
                end
            end
            default: lvl = '0;
        endcase
    end

    assign level = (lvl > LVL_W'(LEVEL_MAX)) ? LEVEL_MAX : lvl[LEVEL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (o_peak.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_peak_channel <= PEAK_CH_W'(i_cmd.idx);
            r_peak_level   <= level;
            r_last_peak    <= i_cmd.last;
        end
    end

    assign o_sts.out_free     = !r_out_valid || o_peak.ready;
    assign o_peak.valid        = r_out_valid;
    assign o_peak.peak_channel = r_peak_channel;
    assign o_peak.peak_level   = r_peak_level;
    assign o_peak.last_peak    = r_last_peak;

endmodule
